// File: rtl/core/rsd_pkg.sv
// ----------------------------------------------------------------------------
// rsd_pkg: shared types and constants of the rank select delete store
// Sizes, operation and status codes, sequencer states, step result struct.
// ----------------------------------------------------------------------------
`default_nettype none

package rsd_pkg;

  localparam int CAPACITY  = 1024;
  localparam int KEY_BITS  = 32;
  localparam int OUT_KEY_W = 32;
  localparam int LEVELS    = $clog2(CAPACITY);   // count tree depth
  localparam int LVL_W     = $clog2(LEVELS);
  localparam int CNT_W     = LEVELS + 1;          // holds 0..CAPACITY
  localparam int OP_W      = 2;
  localparam int ST_W      = 2;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_SELECT = 2'd1,
    OP_DELETE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_KEY
  } state_e;

  // One level of the count tree walk
  typedef struct packed {
    logic              go_left;
    logic              cnt_we;
    logic [CNT_W-1:0]  cnt_wdata;
    logic [CNT_W-1:0]  rank_next;
    logic [LEVELS-1:0] path_next;
  } step_t;

endpackage

`default_nettype wire

// File: rtl/core/rsd_in_if.sv
// ----------------------------------------------------------------------------
// rsd_in_if: request channel of the rank select delete store
// Valid/ready channel carrying operation, key and rank.
// ----------------------------------------------------------------------------
`default_nettype none

interface rsd_in_if import rsd_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [OP_W-1:0]            operation;
  logic signed [OUT_KEY_W-1:0] key_in;
  logic [CNT_W-1:0]           rank;

  modport source (output valid, output operation, output key_in, output rank,
                  input ready);
  modport sink   (input valid, input operation, input key_in, input rank,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/core/rsd_out_if.sv
// ----------------------------------------------------------------------------
// rsd_out_if: response channel of the rank select delete store
// Valid/ready channel carrying key, status and live count.
// ----------------------------------------------------------------------------
`default_nettype none

interface rsd_out_if import rsd_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [OUT_KEY_W-1:0] key_out;
  logic [ST_W-1:0]             status;
  logic [CNT_W-1:0]            live_count;

  modport source (output valid, output key_out, output status, output live_count,
                  input ready);
  modport sink   (input valid, input key_out, input status, input live_count,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/core/rsd_step.sv
// ----------------------------------------------------------------------------
// rsd_step: one level of the count tree walk
// Picks the branch, forms the left count update and the remaining rank.
// ----------------------------------------------------------------------------
`default_nettype none

module rsd_step import rsd_pkg::*; (
  input  op_e               op_i,
  input  logic [LVL_W-1:0]  level_i,
  input  logic [LEVELS-1:0] path_i,
  input  logic [CNT_W-1:0]  rank_i,
  input  logic [CNT_W-1:0]  slots_i,
  input  logic [CNT_W-1:0]  rd_cnt_i,
  output step_t             step_o
);

  logic [LVL_W-1:0] bit_pos;
  logic             node_live;
  logic [CNT_W-1:0] left_cnt;
  logic             is_append;

  // path_i is the lowest slot under the node's left subtree; a node whose
  // left subtree lies wholly at or past the fill count holds stale data.
  assign bit_pos   = LVL_W'(LEVELS - 1) - level_i;
  assign node_live = CNT_W'(path_i) < slots_i;
  assign left_cnt  = node_live ? rd_cnt_i : '0;
  assign is_append = (op_i == OP_APPEND);

  always_comb begin
    step_o = '0;
    if (is_append) begin
      step_o.go_left = ~slots_i[bit_pos];
    end else begin
      step_o.go_left = (rank_i <= left_cnt);
    end
    step_o.cnt_we    = step_o.go_left && (is_append || (op_i == OP_DELETE));
    step_o.cnt_wdata = is_append ? left_cnt + CNT_W'(1) : left_cnt - CNT_W'(1);
    step_o.rank_next = (step_o.go_left || is_append) ? rank_i : rank_i - left_cnt;
    step_o.path_next = path_i;
    step_o.path_next[bit_pos] = ~step_o.go_left;
  end

endmodule

`default_nettype wire

// File: rtl/core/rank_select_delete_store_core.sv
// ----------------------------------------------------------------------------
// rank_select_delete_store_core: ordered key store with rank access
// Append, select by rank, delete by rank and clear over a count tree.
// ----------------------------------------------------------------------------
// Keys are appended in order into slots 0..1023 of a key RAM; a select or
// delete finds the rank-th live key (1-based) by walking a binary count tree
// from the root, one level per cycle, through a single shared step unit.
// Each internal node keeps the number of live keys in its left subtree, in a
// 1024 x 11 RAM with one read and one write port. From acceptance to a
// valid response, select/delete walk the 10 tree levels and then do the
// registered key read, append walks the 10 levels updating left counts, and
// clear and error responses are registered straight from idle. The tree
// depth sets the length of the walk. The block takes one item at a time and
// is ready again once the response has been transferred. Clear takes effect
// at once: a node count is only trusted when its left subtree starts below
// the fill count, so no clearing pass is needed and the block is ready right
// out of reset. Slots freed by delete are not reused before a clear; an
// append to a full store returns the full status, and a rank of zero or past
// the live count returns the range status, both leaving the state untouched.
// ----------------------------------------------------------------------------
`default_nettype none

module rank_select_delete_store_core import rsd_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  rsd_in_if.sink     in_ch,
  rsd_out_if.source  out_ch
);

  // sequencer and item registers
  state_e            state_q, state_d;
  op_e               op_q, op_d;
  logic [CNT_W-1:0]  rank_q, rank_d;
  logic [LEVELS-1:0] path_q, path_d;
  logic [LVL_W-1:0]  level_q, level_d;
  logic [LEVELS-1:0] node_q, node_d;
  logic [CNT_W-1:0]  slots_q, slots_d;
  logic [CNT_W-1:0]  live_q, live_d;

  // response register
  logic                 out_valid_q, out_valid_d;
  logic [OUT_KEY_W-1:0] key_out_q, key_out_d;
  status_e              status_q, status_d;

  // memories
  logic [CNT_W-1:0]    cnt_mem [CAPACITY];
  logic [CNT_W-1:0]    cnt_rdata_q;
  logic [LEVELS-1:0]   cnt_raddr;
  logic                cnt_we;
  logic [CNT_W-1:0]    cnt_wdata;

  logic [KEY_BITS-1:0] key_mem [CAPACITY];
  logic [KEY_BITS-1:0] key_rdata_q;
  logic [LEVELS-1:0]   key_raddr;
  logic                key_we;
  logic [KEY_BITS-1:0] key_wdata;

  logic  in_xfer;
  op_e   in_op;
  step_t step;

  assign in_ch.ready = (state_q == S_IDLE) && !out_valid_q;
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign in_op       = op_e'(in_ch.operation);

  assign out_ch.valid      = out_valid_q;
  assign out_ch.key_out    = key_out_q;
  assign out_ch.status     = status_q;
  assign out_ch.live_count = live_q;

  rsd_step u_step (
    .op_i     (op_q),
    .level_i  (level_q),
    .path_i   (path_q),
    .rank_i   (rank_q),
    .slots_i  (slots_q),
    .rd_cnt_i (cnt_rdata_q),
    .step_o   (step)
  );

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    rank_d      = rank_q;
    path_d      = path_q;
    level_d     = level_q;
    node_d      = node_q;
    slots_d     = slots_q;
    live_d      = live_q;
    out_valid_d = out_valid_q && !out_ch.ready;
    key_out_d   = key_out_q;
    status_d    = status_q;
    cnt_raddr   = {node_q[LEVELS-2:0], ~step.go_left};
    cnt_we      = 1'b0;
    cnt_wdata   = step.cnt_wdata;
    key_we      = 1'b0;
    key_wdata   = KEY_BITS'(in_ch.key_in);
    key_raddr   = step.path_next;

    case (state_q)
      S_IDLE: begin
        cnt_raddr = LEVELS'(1);   // root
        if (in_xfer) begin
          op_d      = in_op;
          rank_d    = in_ch.rank;
          path_d    = '0;
          level_d   = '0;
          node_d    = LEVELS'(1);
          key_out_d = '0;
          status_d  = ST_OK;
          case (in_op)
            OP_CLEAR: begin
              slots_d     = '0;
              live_d      = '0;
              out_valid_d = 1'b1;
            end
            OP_APPEND: begin
              if (slots_q == CNT_W'(CAPACITY)) begin
                status_d    = ST_FULL;
                out_valid_d = 1'b1;
              end else begin
                key_we  = 1'b1;
                state_d = S_WALK;
              end
            end
            default: begin
              if ((in_ch.rank == '0) || (in_ch.rank > live_q)) begin
                status_d    = ST_RANGE;
                out_valid_d = 1'b1;
              end else begin
                state_d = S_WALK;
              end
            end
          endcase
        end
      end

      S_WALK: begin
        // left count of node_q is in cnt_rdata_q; child read goes out now
        cnt_we = step.cnt_we;
        rank_d = step.rank_next;
        path_d = step.path_next;
        node_d = {node_q[LEVELS-2:0], ~step.go_left};
        if (level_q == LVL_W'(LEVELS - 1)) begin
          if (op_q == OP_APPEND) begin
            slots_d     = slots_q + CNT_W'(1);
            live_d      = live_q + CNT_W'(1);
            out_valid_d = 1'b1;
            state_d     = S_IDLE;
          end else begin
            state_d = S_KEY;
          end
        end else begin
          level_d = level_q + LVL_W'(1);
        end
      end

      S_KEY: begin
        key_out_d   = OUT_KEY_W'(signed'(key_rdata_q));
        out_valid_d = 1'b1;
        if (op_q == OP_DELETE) begin
          live_d = live_q - CNT_W'(1);
        end
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      slots_q     <= '0;
      live_q      <= '0;
      out_valid_q <= 1'b0;
      op_q        <= OP_APPEND;
      level_q     <= '0;
    end else begin
      state_q     <= state_d;
      slots_q     <= slots_d;
      live_q      <= live_d;
      out_valid_q <= out_valid_d;
      op_q        <= op_d;
      level_q     <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rank_q    <= rank_d;
    path_q    <= path_d;
    node_q    <= node_d;
    key_out_q <= key_out_d;
    status_q  <= status_d;
  end

  // left-count RAM: node being walked is written while its child is read
  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[node_q] <= cnt_wdata;
    end
    cnt_rdata_q <= cnt_mem[cnt_raddr];
  end

  // key RAM: written at the fill slot on append, read at the found slot
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[slots_q[LEVELS-1:0]] <= key_wdata;
    end
    key_rdata_q <= key_mem[key_raddr];
  end

endmodule

`default_nettype wire
